[hdl/rpn_pkg.sv]
// Shared types and constants for the RPN stack evaluator.
`timescale 1ns / 1ps

package rpn_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int FILL_W      = $clog2(STACK_DEPTH + 1);

  localparam int VAL_W      = 32;
  localparam int FRAC_W     = 16;
  localparam int OP_W       = 4;
  localparam int STATUS_W   = 3;
  localparam int FILL_OUT_W = 7;

  localparam int DIV_W     = VAL_W + FRAC_W;
  localparam int DIV_STEPS = DIV_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_MUL   = 4'd3,
    OP_DIV   = 4'd4,
    OP_REM   = 4'd5,
    OP_PEEK  = 4'd6,
    OP_SWAP  = 4'd7,
    OP_DUP   = 4'd8,
    OP_CLEAR = 4'd9,
    OP_ENDL  = 4'd10
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_FULL  = 3'd2,
    ST_ZDIV  = 3'd3,
    ST_FRAC  = 3'd4,
    ST_SAT   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    AO_ADD,
    AO_SUB,
    AO_MUL,
    AO_DIV,
    AO_REM
  } alu_op_t;

  typedef enum logic [1:0] {
    AL_IDLE,
    AL_MUL,
    AL_DIV,
    AL_FIN
  } alu_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_POPB,
    S_POPA,
    S_EXEC,
    S_WAIT,
    S_SHOW,
    S_SW1,
    S_SW2,
    S_SW3,
    S_DUP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                    start;
    alu_op_t                 op;
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [VAL_W-1:0] result;
    logic                    sat;
  } alu_rsp_t;

endpackage

[hdl/rpn_in_if.sv]
// Command channel: valid/ready handshake carrying op and number.
`timescale 1ns / 1ps

interface rpn_in_if import rpn_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic signed [VAL_W-1:0] number;

  modport source (output valid, output op, output number, input ready);
  modport sink   (input valid, input op, input number, output ready);
endinterface

[hdl/rpn_out_if.sv]
// Result channel: valid/ready handshake carrying the shown value, status and fill.
`timescale 1ns / 1ps

interface rpn_out_if import rpn_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] shown_value;
  logic                    shown_valid;
  logic [STATUS_W-1:0]     status;
  logic [FILL_OUT_W-1:0]   fill;

  modport source (output valid, output shown_value, output shown_valid,
                  output status, output fill, input ready);
  modport sink   (input valid, input shown_value, input shown_valid,
                  input status, input fill, output ready);
endinterface

[hdl/rpn_ram.sv]
// Simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module rpn_ram #(
  parameter int  DEPTH = 64,
  parameter int  WIDTH = 32,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/rpn_alu.sv]
// Shared arithmetic unit: saturating add/sub and multiply, 48-step divider.
`timescale 1ns / 1ps

module rpn_alu import rpn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  localparam logic [DIV_W-1:0] Q_POS_LIM = {{FRAC_W{1'b0}}, 1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [DIV_W-1:0] Q_NEG_LIM = {{FRAC_W{1'b0}}, 1'b1, {(VAL_W-1){1'b0}}};

  alu_state_t al_state_r, al_state_nxt;

  logic signed [2*VAL_W-1:0] p_r;
  logic [DIV_W-1:0]          dvd_r;
  logic [VAL_W-1:0]          rem_r;
  logic [VAL_W-1:0]          dvs_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      neg_q_r;
  logic                      neg_r_r;
  logic                      is_rem_r;

  logic                      done_r, done_nxt;
  logic signed [VAL_W-1:0]   result_r, result_nxt;
  logic                      sat_r, sat_nxt;

  logic [VAL_W-1:0] mag_a, mag_b;
  logic signed [VAL_W:0] sum;
  logic [VAL_W:0]   trial, diff;
  logic             ge;
  logic             mul_ovf;
  logic [VAL_W-1:0] q_low;

  assign mag_a = req.a[VAL_W-1] ? VAL_W'(-req.a) : VAL_W'(req.a);
  assign mag_b = req.b[VAL_W-1] ? VAL_W'(-req.b) : VAL_W'(req.b);

  always_comb begin
    if (req.op == AO_SUB) begin
      sum = {req.a[VAL_W-1], req.a} - {req.b[VAL_W-1], req.b};
    end else begin
      sum = {req.a[VAL_W-1], req.a} + {req.b[VAL_W-1], req.b};
    end
  end

  // one restoring-division step
  assign trial = {rem_r, dvd_r[DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  // product fits iff the bits above the kept field all match its sign
  assign mul_ovf = !((&p_r[2*VAL_W-1:VAL_W+FRAC_W-1]) || (~|p_r[2*VAL_W-1:VAL_W+FRAC_W-1]));
  assign q_low   = dvd_r[VAL_W-1:0];

  always_comb begin
    al_state_nxt = al_state_r;
    case (al_state_r)
      AL_IDLE: begin
        if (req.start) begin
          if (req.op == AO_MUL) begin
            al_state_nxt = AL_MUL;
          end else if (req.op == AO_DIV || req.op == AO_REM) begin
            al_state_nxt = AL_DIV;
          end
        end
      end
      AL_MUL:  al_state_nxt = AL_IDLE;
      AL_DIV: begin
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          al_state_nxt = AL_FIN;
        end
      end
      AL_FIN:  al_state_nxt = AL_IDLE;
      default: al_state_nxt = AL_IDLE;
    endcase
  end

  always_comb begin
    done_nxt   = 1'b0;
    result_nxt = result_r;
    sat_nxt    = sat_r;
    case (al_state_r)
      AL_IDLE: begin
        if (req.start && (req.op == AO_ADD || req.op == AO_SUB)) begin
          done_nxt = 1'b1;
          sat_nxt  = sum[VAL_W] != sum[VAL_W-1];
          if (sat_nxt) begin
            result_nxt = sum[VAL_W] ? VAL_MIN : VAL_MAX;
          end else begin
            result_nxt = sum[VAL_W-1:0];
          end
        end
      end
      AL_MUL: begin
        done_nxt = 1'b1;
        sat_nxt  = mul_ovf;
        if (mul_ovf) begin
          result_nxt = p_r[2*VAL_W-1] ? VAL_MIN : VAL_MAX;
        end else begin
          result_nxt = p_r[VAL_W+FRAC_W-1:FRAC_W];
        end
      end
      AL_FIN: begin
        done_nxt = 1'b1;
        sat_nxt  = 1'b0;
        if (is_rem_r) begin
          result_nxt = neg_r_r ? VAL_W'(-rem_r) : rem_r;
        end else if (!neg_q_r && dvd_r > Q_POS_LIM) begin
          sat_nxt    = 1'b1;
          result_nxt = VAL_MAX;
        end else if (neg_q_r && dvd_r > Q_NEG_LIM) begin
          sat_nxt    = 1'b1;
          result_nxt = VAL_MIN;
        end else begin
          result_nxt = neg_q_r ? VAL_W'(-q_low) : q_low;
        end
      end
      default: begin
        done_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      al_state_r <= AL_IDLE;
      done_r     <= 1'b0;
    end else begin
      al_state_r <= al_state_nxt;
      done_r     <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
    sat_r    <= sat_nxt;
    if (al_state_r == AL_IDLE && req.start) begin
      p_r      <= (2*VAL_W)'(req.a) * (2*VAL_W)'(req.b);
      is_rem_r <= req.op == AO_REM;
      neg_q_r  <= req.a[VAL_W-1] ^ req.b[VAL_W-1];
      neg_r_r  <= req.a[VAL_W-1];
      dvs_r    <= mag_b;
      rem_r    <= '0;
      cnt_r    <= '0;
      if (req.op == AO_REM) begin
        dvd_r <= {{FRAC_W{1'b0}}, mag_a};
      end else begin
        dvd_r <= {mag_a, {FRAC_W{1'b0}}};
      end
    end else if (al_state_r == AL_DIV) begin
      rem_r <= ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
      dvd_r <= {dvd_r[DIV_W-2:0], ge};
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  assign rsp = '{done: done_r, result: result_r, sat: sat_r};

endmodule

[hdl/rpn_stack_evaluator.sv]
// Top level: command sequencer over the value stack and the shared ALU.
`timescale 1ns / 1ps

// Reverse Polish evaluator on signed Q16.16 values over a 64-entry stack.
// in_ch carries one command per transaction (op, number); out_ch returns one
// result per command (shown_value, shown_valid, status, fill). Commands are
// handled one at a time: in_ch.ready is high only while the sequencer idles.
// From acceptance, each command runs through S_START and the states of its op
// to S_DONE, where the result loads; div/rem wait out the 48 one-bit steps of
// the shared divider. The next command is taken in the cycle after the result
// loads. The stack RAM has one write port and one registered read port, so
// each operand read is registered and swap writes its two entries in turn.
// The result sits in an output register; the next command is accepted while
// it waits. If the receiver stalls, a finished command holds in its last
// state until the output register frees up. Reset (rst_n low, synchronous)
// empties the stack, clears the report suppression and drops any pending
// result; stack contents need no clearing pass.
module rpn_stack_evaluator import rpn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  rpn_in_if.sink   in_ch,
  rpn_out_if.source out_ch
);

  state_t state_r, state_nxt;

  op_t                     op_r, op_nxt;
  logic signed [VAL_W-1:0] num_r, num_nxt;
  logic [FILL_W-1:0]       fill_r, fill_nxt;
  logic                    supp_r, supp_nxt;
  status_t                 status_r, status_nxt;
  logic signed [VAL_W-1:0] shown_r, shown_nxt;
  logic                    shown_vld_r, shown_vld_nxt;
  logic signed [VAL_W-1:0] a_r, a_nxt;
  logic signed [VAL_W-1:0] b_r, b_nxt;
  logic [VAL_W-1:0]        t_r, t_nxt;
  logic                    pop_ok_r, pop_ok_nxt;

  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic                    out_shown_r;
  status_t                 out_status_r;
  logic [FILL_W-1:0]       out_fill_r;

  logic                    ram_we, ram_re;
  logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
  logic [VAL_W-1:0]        ram_wdata, ram_rdata;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic              accept, out_load;
  logic              not_empty, not_full, two_plus;
  logic [ADDR_W-1:0] top_addr, sec_addr, push_addr;
  logic signed [VAL_W-1:0] rd_val;
  logic              binop, divop;

  assign accept    = in_ch.valid && in_ch.ready;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign not_empty = fill_r != '0;
  assign not_full  = fill_r < FILL_W'(STACK_DEPTH);
  assign two_plus  = fill_r >= FILL_W'(2);
  assign top_addr  = ADDR_W'(fill_r - FILL_W'(1));
  assign sec_addr  = ADDR_W'(fill_r - FILL_W'(2));
  assign push_addr = ADDR_W'(fill_r);
  assign rd_val    = pop_ok_r ? ram_rdata : '0;
  assign binop     = op_r == OP_ADD || op_r == OP_SUB || op_r == OP_MUL ||
                     op_r == OP_DIV || op_r == OP_REM;
  assign divop     = op_r == OP_DIV || op_r == OP_REM;

  rpn_ram #(.DEPTH(STACK_DEPTH), .WIDTH(VAL_W)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rpn_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        state_nxt = S_DONE;
        if (binop) begin
          state_nxt = S_POPB;
        end else if (op_r == OP_PEEK && not_empty) begin
          state_nxt = S_SHOW;
        end else if (op_r == OP_SWAP && two_plus) begin
          state_nxt = S_SW1;
        end else if (op_r == OP_DUP && not_empty && not_full) begin
          state_nxt = S_DUP;
        end else if (op_r == OP_ENDL && !supp_r && not_empty) begin
          state_nxt = S_SHOW;
        end
      end
      S_POPB: begin
        if (divop && rd_val == '0) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_POPA;
        end
      end
      S_POPA:  state_nxt = S_EXEC;
      S_EXEC: begin
        if (op_r == OP_REM && (a_r[FRAC_W-1:0] != '0 || b_r[FRAC_W-1:0] != '0)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (alu_rsp.done) begin
          state_nxt = S_DONE;
        end
      end
      S_SHOW:  state_nxt = S_DONE;
      S_SW1:   state_nxt = S_SW2;
      S_SW2:   state_nxt = S_SW3;
      S_SW3:   state_nxt = S_DONE;
      S_DUP:   state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and stack control
  always_comb begin
    op_nxt        = op_r;
    num_nxt       = num_r;
    fill_nxt      = fill_r;
    supp_nxt      = supp_r;
    status_nxt    = status_r;
    shown_nxt     = shown_r;
    shown_vld_nxt = shown_vld_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    t_nxt         = t_r;
    pop_ok_nxt    = pop_ok_r;
    ram_we        = 1'b0;
    ram_waddr     = push_addr;
    ram_wdata     = num_r;
    ram_re        = 1'b0;
    ram_raddr     = top_addr;
    alu_req.start = 1'b0;
    alu_req.a     = a_r;
    alu_req.b     = b_r;
    case (op_r)
      OP_SUB:  alu_req.op = AO_SUB;
      OP_MUL:  alu_req.op = AO_MUL;
      OP_DIV:  alu_req.op = AO_DIV;
      OP_REM:  alu_req.op = AO_REM;
      default: alu_req.op = AO_ADD;
    endcase

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt        = op_t'(in_ch.op);
          num_nxt       = in_ch.number;
          status_nxt    = ST_OK;
          shown_nxt     = '0;
          shown_vld_nxt = 1'b0;
        end
      end
      S_START: begin
        case (op_r)
          OP_PUSH: begin
            supp_nxt = 1'b0;
            if (not_full) begin
              ram_we   = 1'b1;
              fill_nxt = fill_r + FILL_W'(1);
            end else begin
              status_nxt = ST_FULL;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM: begin
            supp_nxt   = 1'b0;
            pop_ok_nxt = not_empty;
            if (not_empty) begin
              ram_re   = 1'b1;
              fill_nxt = fill_r - FILL_W'(1);
            end else begin
              status_nxt = ST_EMPTY;
            end
          end
          OP_PEEK: begin
            supp_nxt = 1'b1;
            ram_re   = not_empty;
          end
          OP_SWAP: begin
            supp_nxt = 1'b1;
            ram_re   = two_plus;
          end
          OP_DUP: begin
            supp_nxt = 1'b1;
            if (not_empty) begin
              if (not_full) begin
                ram_re = 1'b1;
              end else begin
                status_nxt = ST_FULL;
              end
            end
          end
          OP_CLEAR: begin
            supp_nxt = 1'b1;
            fill_nxt = '0;
          end
          OP_ENDL: begin
            supp_nxt = 1'b0;
            if (!supp_r) begin
              if (not_empty) begin
                ram_re   = 1'b1;
                fill_nxt = fill_r - FILL_W'(1);
              end else begin
                shown_vld_nxt = 1'b1;
                status_nxt    = ST_EMPTY;
              end
            end
          end
          default: begin
            supp_nxt = supp_r;
          end
        endcase
      end
      S_POPB: begin
        b_nxt = rd_val;
        if (divop && rd_val == '0) begin
          // zero divisor: leave the dividend in place
          if (status_r == ST_OK) begin
            status_nxt = ST_ZDIV;
          end
        end else begin
          pop_ok_nxt = not_empty;
          if (not_empty) begin
            ram_re   = 1'b1;
            fill_nxt = fill_r - FILL_W'(1);
          end else if (status_r == ST_OK) begin
            status_nxt = ST_EMPTY;
          end
        end
      end
      S_POPA: begin
        a_nxt = rd_val;
      end
      S_EXEC: begin
        if (op_r == OP_REM && (a_r[FRAC_W-1:0] != '0 || b_r[FRAC_W-1:0] != '0)) begin
          if (status_r == ST_OK) begin
            status_nxt = ST_FRAC;
          end
        end else begin
          alu_req.start = 1'b1;
        end
      end
      S_WAIT: begin
        ram_wdata = alu_rsp.result;
        if (alu_rsp.done) begin
          // operands were popped, so there is always room for the result
          ram_we   = 1'b1;
          fill_nxt = fill_r + FILL_W'(1);
          if (alu_rsp.sat && status_r == ST_OK) begin
            status_nxt = ST_SAT;
          end
        end
      end
      S_SHOW: begin
        shown_nxt     = ram_rdata;
        shown_vld_nxt = 1'b1;
      end
      S_SW1: begin
        t_nxt     = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = sec_addr;
      end
      S_SW2: begin
        ram_we    = 1'b1;
        ram_waddr = top_addr;
        ram_wdata = ram_rdata;
      end
      S_SW3: begin
        ram_we    = 1'b1;
        ram_waddr = sec_addr;
        ram_wdata = t_r;
      end
      S_DUP: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        fill_nxt  = fill_r + FILL_W'(1);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      supp_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      supp_r  <= supp_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    num_r       <= num_nxt;
    status_r    <= status_nxt;
    shown_r     <= shown_nxt;
    shown_vld_r <= shown_vld_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    t_r         <= t_nxt;
    pop_ok_r    <= pop_ok_nxt;
    if (out_load) begin
      out_value_r  <= shown_r;
      out_shown_r  <= shown_vld_r;
      out_status_r <= status_r;
      out_fill_r   <= fill_r;
    end
  end

  assign in_ch.ready        = state_r == S_IDLE;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.shown_value = out_value_r;
  assign out_ch.shown_valid = out_shown_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.fill        = FILL_OUT_W'(out_fill_r);

endmodule
